// ===== rtl/core/bdq_pkg.sv =====
// Package for the bounded deque with value delete.
// Holds sizes, derived widths, the command codes and the slot wrap helper.
// Used by bounded_deque_with_value_delete; depends on nothing.
package bdq_pkg;

   localparam int DEPTH      = 32;
   localparam int READ_LIMIT = 32;
   localparam int VAL_W      = 32;
   localparam int CNTIN_W    = 6;
   localparam int CMDIN_W    = 4;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CMP_W      = (CNT_W > CNTIN_W) ? CNT_W : CNTIN_W;

   typedef enum logic [CMDIN_W-1:0] {
      CMD_PUSH_FRONT = 4'd0,
      CMD_PUSH_BACK  = 4'd1,
      CMD_POP_FRONT  = 4'd2,
      CMD_POP_BACK   = 4'd3,
      CMD_CLEAR      = 4'd4,
      CMD_DELETE     = 4'd5,
      CMD_READ_ALL   = 4'd6,
      CMD_READ_FIRST = 4'd7,
      CMD_READ_LAST  = 4'd8
   } cmd_type;

   // wrap front + offset into the circular store; offset stays below DEPTH
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                                input logic [IDX_W-1:0] offset);
      logic [IDX_W:0] sum;
      sum = {1'b0, front} + {1'b0, offset};
      if (sum >= (IDX_W+1)'(DEPTH)) begin
         sum = sum - (IDX_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== rtl/core/bounded_deque_with_value_delete.sv =====
// Bounded double-ended queue of signed 32-bit values with delete by value.
// Circular entry memory, one sequencer, one shared compare for delete.
// Depends on bdq_pkg.
//
// Usage:
//   The req_ channel carries one command per item (push front/back, pop
//   front/back, clear, delete value, read all, read first n, read last n).
//   req_stall is high while a command is in progress or a result waits in
//   the output register. The rsp_ channel returns results from a single
//   output register; rsp_last marks the final result of a command.
//   Push, pop and clear are done in the idle state and give no result, except a
//   push into a full store, which gives one overflow result.
//   Delete value walks the held entries at one per cycle through the
//   memory read port and the shared comparator.
//   A read gives one result per entry, each through a memory read, then
//   an output load; an empty read gives one result without a value.
//   rsp_stall holds the output register and the sequencer; nothing is
//   lost. Reset empties the store at once, with no clearing pass.
module bounded_deque_with_value_delete
   import bdq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CMDIN_W-1:0]        req_cmd,
   input  logic signed [VAL_W-1:0]   req_operand_value,
   input  logic [CNTIN_W-1:0]        req_read_count,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VAL_W-1:0]   rsp_entry_value,
   output logic                      rsp_has_value,
   output logic                      rsp_last,
   output logic                      rsp_overflow
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEL_CMP,
      ST_RD_LOAD,
      ST_RD_SEND
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      front_ff, front_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic [CMP_W-1:0]      left_ff, left_in;
   logic [VAL_W-1:0]      key_ff, key_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                  rsp_has_ff, rsp_has_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic [VAL_W-1:0]      entry_store_ff [DEPTH];
   logic [VAL_W-1:0]      mem_q_ff;

   logic                  rd_en;
   logic [IDX_W-1:0]      rd_off;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_off;
   logic [IDX_W-1:0]      wr_addr;
   logic                  wr_at_front;
   logic [VAL_W-1:0]      wr_data;

   logic                  req_accept;
   logic                  rsp_accept;
   logic                  is_full;
   logic [IDX_W-1:0]      front_dec;
   logic [CMP_W-1:0]      fill_ext;
   logic [CMP_W-1:0]      cnt_min;
   logic [CMP_W-1:0]      n_all;
   logic [CMP_W-1:0]      n_cnt;
   logic [CMP_W-1:0]      i_next;
   logic                  key_match;

   assign req_stall  = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = signed'(rsp_value_ff);
   assign rsp_has_value   = rsp_has_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   assign is_full   = (fill_ff == CNT_W'(DEPTH));
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
   assign fill_ext  = CMP_W'(fill_ff);
   assign cnt_min   = (CMP_W'(req_read_count) < fill_ext) ? CMP_W'(req_read_count)
                                                          : fill_ext;
   assign n_all     = (fill_ext > CMP_W'(READ_LIMIT)) ? CMP_W'(READ_LIMIT) : fill_ext;
   assign n_cnt     = (cnt_min > CMP_W'(READ_LIMIT)) ? CMP_W'(READ_LIMIT) : cnt_min;
   assign i_next    = CMP_W'(idx_ff) + CMP_W'(1);
   assign key_match = (mem_q_ff == key_ff);

   assign rd_addr = slot_of(front_ff, rd_off);
   assign wr_addr = wr_at_front ? front_dec : slot_of(front_ff, wr_off);

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      left_in      = left_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_accept;
      rsp_value_in = rsp_value_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rd_en        = 1'b0;
      rd_off       = '0;
      wr_en        = 1'b0;
      wr_off       = '0;
      wr_at_front  = 1'b0;
      wr_data      = req_operand_value;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (cmd_type'(req_cmd))
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_valid_in = 1'b1;
                        rsp_value_in = '0;
                        rsp_has_in   = 1'b0;
                        rsp_last_in  = 1'b1;
                        rsp_ovf_in   = 1'b1;
                     end else begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + CNT_W'(1);
                        if (cmd_type'(req_cmd) == CMD_PUSH_FRONT) begin
                           wr_at_front = 1'b1;
                           front_in    = front_dec;
                        end else begin
                           wr_off = IDX_W'(fill_ff);
                        end
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (fill_ff != '0) begin
                        front_in = (front_ff == IDX_W'(DEPTH - 1)) ? '0
                                                                   : front_ff + IDX_W'(1);
                        fill_in  = fill_ff - CNT_W'(1);
                     end
                  end
                  CMD_POP_BACK: begin
                     if (fill_ff != '0) begin
                        fill_in = fill_ff - CNT_W'(1);
                     end
                  end
                  CMD_CLEAR: begin
                     front_in = '0;
                     fill_in  = '0;
                  end
                  CMD_DELETE: begin
                     if (fill_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_off   = '0;
                        idx_in   = '0;
                        k_in     = '0;
                        key_in   = req_operand_value;
                        state_in = ST_DEL_CMP;
                     end
                  end
                  CMD_READ_ALL, CMD_READ_FIRST, CMD_READ_LAST: begin
                     if (cmd_type'(req_cmd) == CMD_READ_ALL) begin
                        left_in = n_all;
                     end else begin
                        left_in = n_cnt;
                     end
                     if (left_in == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_value_in = '0;
                        rsp_has_in   = 1'b0;
                        rsp_last_in  = 1'b1;
                        rsp_ovf_in   = 1'b0;
                     end else begin
                        if (cmd_type'(req_cmd) == CMD_READ_LAST) begin
                           rd_off = IDX_W'(fill_ext - left_in);
                        end else begin
                           rd_off = '0;
                        end
                        rd_en    = 1'b1;
                        idx_in   = IDX_W'(CMP_W'(rd_off) + CMP_W'(1));
                        state_in = ST_RD_LOAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DEL_CMP: begin
            // keep non-matching entries, compacted toward the front
            if (!key_match) begin
               wr_en   = 1'b1;
               wr_off  = IDX_W'(k_ff);
               wr_data = mem_q_ff;
               k_in    = k_ff + CNT_W'(1);
            end
            if (i_next == fill_ext) begin
               fill_in  = k_in;
               state_in = ST_IDLE;
            end else begin
               rd_en  = 1'b1;
               rd_off = IDX_W'(i_next);
               idx_in = IDX_W'(i_next);
            end
         end
         ST_RD_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = mem_q_ff;
            rsp_has_in   = 1'b1;
            rsp_last_in  = (left_ff == CMP_W'(1));
            rsp_ovf_in   = 1'b0;
            left_in      = left_ff - CMP_W'(1);
            state_in     = (left_ff == CMP_W'(1)) ? ST_IDLE : ST_RD_SEND;
         end
         ST_RD_SEND: begin
            if (rsp_accept) begin
               rd_en    = 1'b1;
               rd_off   = idx_ff;
               idx_in   = IDX_W'(CMP_W'(idx_ff) + CMP_W'(1));
               state_in = ST_RD_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      k_ff         <= k_in;
      left_ff      <= left_in;
      key_ff       <= key_in;
      rsp_value_ff <= rsp_value_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= entry_store_ff[rd_addr];
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_flag_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> !rsp_has_ff && rsp_last_ff)
      else $error("overflow result carries a value or lacks last");

   a_del_compact: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DEL_CMP |-> CMP_W'(k_ff) <= CMP_W'(idx_ff))
      else $error("delete write index passed read index");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_cmd == CMD_CLEAR |=> fill_ff == '0 && front_ff == '0)
      else $error("clear did not empty the store");

   a_del_keeps_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DEL_CMP |-> !rsp_valid_ff)
      else $error("result pending during delete");

endmodule
